FILE: rtl/core/sia_pkg.sv
// shared types and constants for the slot identifier allocator
package sia_pkg;

    // identifier space and capacity
    localparam int MAX_SLOTS = 256;
    localparam int ID_W      = 8;
    localparam int ID_SPACE  = 1 << ID_W;
    localparam int CNT_W     = ID_W + 1;
    localparam int CAP_INT   = (MAX_SLOTS < ID_SPACE) ? MAX_SLOTS : ID_SPACE;
    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(CAP_INT);

    typedef logic [ID_W-1:0]  id_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // request kinds
    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FREE  = 2'd2,
        STATUS_FULL  = 2'd3
    } status_t;

    // free queue update command
    typedef struct packed {
        logic pop;
        logic push;
        id_t  push_id;
    } sia_qcmd_t;

endpackage

FILE: rtl/core/slot_id_allocator.sv
// slot identifier allocator top level: request decode, in-use map and result register
//
// Allocate requests reuse the oldest released identifier first and otherwise
// issue the next never-used one from a high-water counter; when neither is
// available the answer is status full. Releases of an identifier at or above
// the high-water mark, or of one already free, are refused and change nothing.
// On acceptance the free queue head and the in-use bit are read from their
// synchronous memories, and in the exec state, when the output can take it, the
// decision is made, both memories are written back and the result is loaded
// into the output register. A new word is taken while a result still waits
// on the output; no clearing pass is needed after reset, since in-use entries
// are only looked at below the high-water mark, where they have been written.
module slot_id_allocator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] slot_id
    input  logic [0:0] s_tuser,   // [0] operation
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] granted_id
    output logic [1:0] m_tuser    // [1:0] status
);
    import sia_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t    state_reg;
    logic      m_tvalid_reg;
    id_t       granted_reg;
    status_t   status_reg;
    op_t       op_reg;
    id_t       id_reg;
    cnt_t      hw_reg, hw_next;

    logic      accept;
    logic      fire;
    id_t       q_head_id;
    logic      q_empty;
    sia_qcmd_t qcmd;
    logic      map_rd;
    logic      map_we;
    id_t       map_waddr;
    logic      map_wdata;
    id_t       granted_next;
    status_t   status_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fire     = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);

    // decision and write-back for the word in flight
    always_comb begin
        hw_next      = hw_reg;
        qcmd         = '0;
        map_we       = 1'b0;
        map_waddr    = id_reg;
        map_wdata    = 1'b0;
        granted_next = '0;
        status_next  = STATUS_OK;
        unique case (op_reg)
            OP_ALLOC: begin
                if (!q_empty) begin
                    granted_next = q_head_id;
                    qcmd.pop     = fire;
                    map_we       = fire;
                    map_waddr    = q_head_id;
                    map_wdata    = 1'b1;
                end else if (hw_reg < CAPACITY) begin
                    granted_next = hw_reg[ID_W-1:0];
                    hw_next      = hw_reg + 1'b1;
                    map_we       = fire;
                    map_waddr    = hw_reg[ID_W-1:0];
                    map_wdata    = 1'b1;
                end else begin
                    status_next = STATUS_FULL;
                end
            end
            OP_RELEASE: begin
                if ({1'b0, id_reg} >= hw_reg) begin
                    status_next = STATUS_RANGE;
                end else if (!map_rd) begin
                    status_next = STATUS_FREE;
                end else begin
                    qcmd.push    = fire;
                    qcmd.push_id = id_reg;
                    map_we       = fire;
                    map_waddr    = id_reg;
                    map_wdata    = 1'b0;
                end
            end
            default: begin
                status_next = STATUS_OK;
            end
        endcase
    end

    // sequencer, request capture and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            hw_reg       <= '0;
        end else begin
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (fire) begin
                        state_reg <= ST_IDLE;
                        hw_reg    <= hw_next;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg <= op_t'(s_tuser[0]);
            id_reg <= s_tdata;
        end
        if (fire) begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = granted_reg;
    assign m_tuser  = status_reg;

    // free identifier queue
    sia_free_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .cmd     (qcmd),
        .head_id (q_head_id),
        .empty   (q_empty)
    );

    // in-use map
    sia_ram #(
        .DATA_W (1),
        .ADDR_W (ID_W)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (map_we),
        .wr_addr (map_waddr),
        .wr_data (map_wdata),
        .rd_en   (accept),
        .rd_addr (s_tdata),
        .rd_data (map_rd)
    );

endmodule

FILE: rtl/core/sia_ram.sv
// generic single write port, single read port synchronous ram
module sia_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/sia_free_queue.sv
// first-in first-out ring of freed identifiers with head, tail and count
module sia_free_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  sia_pkg::sia_qcmd_t cmd,
    output sia_pkg::id_t      head_id,
    output logic              empty
);
    import sia_pkg::*;

    id_t  head_reg, head_next;
    id_t  tail_reg, tail_next;
    cnt_t count_reg, count_next;

    // pointer and count update
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.pop) begin
            head_next = head_reg + 1'b1;
        end
        if (cmd.push) begin
            tail_next = tail_reg + 1'b1;
        end
        if (cmd.pop && !cmd.push) begin
            count_next = count_reg - 1'b1;
        end else if (cmd.push && !cmd.pop) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign empty = (count_reg == '0);

    // ring storage, head entry fetched on request
    sia_ram #(
        .DATA_W (ID_W),
        .ADDR_W (ID_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (cmd.push),
        .wr_addr (tail_reg),
        .wr_data (cmd.push_id),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (head_id)
    );

endmodule
